/* sv/mrs_pkg.sv */
// Package for the Modbus RTU register slave: payload structs, codes,
// control structs and the CRC-16 byte step. No dependencies.
package mrs_pkg;

    typedef struct packed {
        logic       cmd;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last;
    } out_item_t;

    localparam logic       CMD_BYTE   = 1'b0;
    localparam logic       CMD_TICK   = 1'b1;
    localparam logic [7:0] FC_READ    = 8'h03;
    localparam logic [7:0] FC_WRITE   = 8'h06;
    localparam logic [7:0] FC_EXC_BIT = 8'h80;
    localparam logic [7:0] EXC_FUNC   = 8'h01;
    localparam logic [7:0] EXC_ADDR   = 8'h02;
    localparam logic [7:0] EXC_VALUE  = 8'h03;
    localparam int         MAX_READ   = 5;
    localparam int         MIN_FRAME  = 4;
    localparam int         FULL_FRAME = 8;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;

    localparam logic [1:0] ADDR_SLAVE = 2'd0;
    localparam logic [1:0] ADDR_IDLE  = 2'd1;

    typedef enum logic [1:0] {
        KIND_EXC,
        KIND_READ,
        KIND_WRITE
    } reply_kind_t;

    typedef struct packed {
        logic rx_write;
        logic tick;
        logic scan_start;
        logic emit_start;
        logic emit_step;
    } mrs_cmd_t;

    typedef struct packed {
        logic frame_end;
        logic scan_done;
        logic reply;
        logic emit_last;
        logic out_free;
    } mrs_status_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

/* sv/mrs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* sv/mrs_datapath.sv */
// Datapath: receive buffer, idle timer, frame scan with CRC check, holding
// registers and response byte generator. Uses mrs_pkg and mrs_ram.
module mrs_datapath
    import mrs_pkg::*;
#(
    parameter int RX_DEPTH  = 64,
    parameter int FRAME_MAX = 60,
    parameter int NUM_REGS  = 5
) (
    input  logic        clk,
    input  logic        rst_n,
    input  mrs_cmd_t    cmd,
    output mrs_status_t status,
    input  logic [7:0]  rx_byte,
    input  logic [7:0]  slave_address,
    input  logic [7:0]  idle_ticks,
    input  logic        out_ready,
    output logic        out_valid,
    output out_item_t   out_data
);
    localparam int CW = $clog2(RX_DEPTH + 1);
    localparam int AW = $clog2(RX_DEPTH);
    localparam int RW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

    logic [CW-1:0]  rx_count_reg;
    logic [CW-1:0]  snap_reg;
    logic [7:0]     idle_reg;
    logic [7:0]     idle_next;
    logic [CW-1:0]  len_reg;
    logic [CW-1:0]  len_next;
    logic [CW-1:0]  rd_idx_reg;
    logic           rd_busy_reg;
    logic           rv_reg;
    logic [CW-1:0]  ridx_reg;
    logic           done_reg;
    logic [15:0]    crc_reg;
    logic           ok_lo_reg;
    logic           ok_hi_reg;
    logic [7:0]     fb_reg [6];
    logic [7:0]     rdata;
    logic [7:0]     hregs_reg [NUM_REGS];

    reply_kind_t    kind_reg;
    reply_kind_t    kind_next;
    logic [7:0]     code_reg;
    logic [7:0]     code_next;
    logic [3:0]     n_reg;
    logic [3:0]     n_next;
    logic [RW-1:0]  start_reg;
    logic [3:0]     k_reg;
    logic [15:0]    ocrc_reg;
    logic           out_valid_reg;
    out_item_t      out_reg;
    logic [7:0]     byte_k;

    logic [15:0]    start16;
    logic [15:0]    count16;
    logic [16:0]    span17;
    logic           frame_ok;
    logic [3:0]     m;
    logic [RW:0]    ridx_sum;

    mrs_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_ram (
        .clk   (clk),
        .we    (cmd.rx_write && (32'(rx_count_reg) < RX_DEPTH)),
        .waddr (rx_count_reg[AW-1:0]),
        .wdata (rx_byte),
        .raddr (rd_idx_reg[AW-1:0]),
        .rdata (rdata)
    );

    assign idle_next = (idle_reg == 8'hFF) ? 8'hFF : idle_reg + 8'd1;
    assign len_next  = (32'(rx_count_reg) < FRAME_MAX) ? rx_count_reg : CW'(FRAME_MAX);

    assign start16 = {fb_reg[2], fb_reg[3]};
    assign count16 = {fb_reg[4], fb_reg[5]};
    assign span17  = {1'b0, start16} + {1'b0, count16};
    assign frame_ok = (32'(len_reg) >= MIN_FRAME) && (fb_reg[0] == slave_address)
                      && ok_lo_reg && ok_hi_reg;

    always_comb
    begin
        kind_next = KIND_EXC;
        code_next = EXC_FUNC;
        n_next    = 4'd3;
        if (fb_reg[1] != FC_READ && fb_reg[1] != FC_WRITE)
        begin
            code_next = EXC_FUNC;
        end
        else if (32'(len_reg) < FULL_FRAME)
        begin
            code_next = EXC_VALUE;
        end
        else if (fb_reg[1] == FC_READ)
        begin
            if (32'(start16) >= NUM_REGS || 32'(count16) > MAX_READ
                || 32'(span17) > NUM_REGS)
            begin
                code_next = EXC_ADDR;
            end
            else
            begin
                kind_next = KIND_READ;
                n_next    = 4'd3 + {count16[2:0], 1'b0};
            end
        end
        else if (32'(start16) >= NUM_REGS)
        begin
            code_next = EXC_ADDR;
        end
        else
        begin
            kind_next = KIND_WRITE;
            n_next    = 4'd6;
        end
    end

    assign m        = k_reg - 4'd3;
    assign ridx_sum = {1'b0, start_reg} + (RW+1)'(m[3:1]);

    always_comb
    begin
        byte_k = 8'h00;
        if (k_reg == n_reg)
        begin
            byte_k = ocrc_reg[7:0];
        end
        else if (k_reg == n_reg + 4'd1)
        begin
            byte_k = ocrc_reg[15:8];
        end
        else if (k_reg == 4'd0)
        begin
            byte_k = fb_reg[0];
        end
        else
        begin
            case (kind_reg)
                KIND_EXC:
                begin
                    byte_k = (k_reg == 4'd1) ? (fb_reg[1] | FC_EXC_BIT) : code_reg;
                end
                KIND_READ:
                begin
                    if (k_reg == 4'd1)
                    begin
                        byte_k = FC_READ;
                    end
                    else if (k_reg == 4'd2)
                    begin
                        byte_k = {4'b0000, n_reg - 4'd3};
                    end
                    else if (m[0])
                    begin
                        byte_k = hregs_reg[ridx_sum[RW-1:0]];
                    end
                end
                KIND_WRITE:
                begin
                    byte_k = fb_reg[k_reg[2:0]];
                end
                default:
                begin
                    byte_k = 8'h00;
                end
            endcase
        end
    end

    assign status.frame_end = (rx_count_reg != '0) && (snap_reg == rx_count_reg)
                              && (idle_next >= idle_ticks);
    assign status.scan_done = done_reg;
    assign status.reply     = frame_ok;
    assign status.emit_last = (k_reg == n_reg + 4'd1);
    assign status.out_free  = !out_valid_reg || out_ready;
    assign out_valid        = out_valid_reg;
    assign out_data         = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_count_reg  <= '0;
            snap_reg      <= '0;
            idle_reg      <= '0;
            rd_busy_reg   <= 1'b0;
            rv_reg        <= 1'b0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_REGS; i++)
            begin
                hregs_reg[i] <= 8'h00;
            end
        end
        else
        begin
            done_reg <= rv_reg && (ridx_reg + CW'(1) == len_reg);
            if (cmd.rx_write && (32'(rx_count_reg) < RX_DEPTH))
            begin
                rx_count_reg <= rx_count_reg + CW'(1);
            end
            if (cmd.tick)
            begin
                if (rx_count_reg == '0)
                begin
                    snap_reg <= '0;
                end
                else if (snap_reg != rx_count_reg)
                begin
                    snap_reg <= rx_count_reg;
                    idle_reg <= 8'h00;
                end
                else if (idle_next >= idle_ticks)
                begin
                    rx_count_reg <= '0;
                    snap_reg     <= '0;
                    idle_reg     <= 8'h00;
                end
                else
                begin
                    idle_reg <= idle_next;
                end
            end
            if (cmd.scan_start)
            begin
                rd_busy_reg <= 1'b1;
            end
            else if (rd_busy_reg && (rd_idx_reg + CW'(1) == len_reg))
            begin
                rd_busy_reg <= 1'b0;
            end
            rv_reg <= rd_busy_reg && !cmd.scan_start;
            if (cmd.emit_start && kind_next == KIND_WRITE)
            begin
                hregs_reg[start16[RW-1:0]] <= fb_reg[5];
            end
            if (cmd.emit_step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tick)
        begin
            len_reg <= len_next;
        end
        if (cmd.scan_start)
        begin
            rd_idx_reg <= '0;
            crc_reg    <= CRC_INIT;
        end
        else if (rd_busy_reg)
        begin
            rd_idx_reg <= rd_idx_reg + CW'(1);
        end
        ridx_reg <= rd_idx_reg;
        if (rv_reg)
        begin
            if (32'(ridx_reg) < 6)
            begin
                fb_reg[ridx_reg[2:0]] <= rdata;
            end
            if (ridx_reg + CW'(2) < len_reg)
            begin
                crc_reg <= crc16_byte(crc_reg, rdata);
            end
            if (ridx_reg + CW'(2) == len_reg)
            begin
                ok_lo_reg <= (rdata == crc_reg[7:0]);
            end
            if (ridx_reg + CW'(1) == len_reg)
            begin
                ok_hi_reg <= (rdata == crc_reg[15:8]);
            end
        end
        if (cmd.emit_start)
        begin
            kind_reg  <= kind_next;
            code_reg  <= code_next;
            n_reg     <= n_next;
            start_reg <= start16[RW-1:0];
            k_reg     <= 4'd0;
            ocrc_reg  <= CRC_INIT;
        end
        else if (cmd.emit_step)
        begin
            k_reg <= k_reg + 4'd1;
            if (k_reg < n_reg)
            begin
                ocrc_reg <= crc16_byte(ocrc_reg, byte_k);
            end
        end
        if (cmd.emit_step)
        begin
            out_reg.tx_byte <= byte_k;
            out_reg.last    <= (k_reg == n_reg + 4'd1);
        end
    end

    a_scan_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !rd_busy_reg)
        else $error("scan done while buffer read still running");
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.tick && status.frame_end) |=> (rx_count_reg == '0))
        else $error("frame end did not clear receive count");
    a_step_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_step |-> status.out_free)
        else $error("response byte loaded over an untaken byte");
endmodule

/* sv/mrs_ctrl.sv */
// Controller state machine: accepts items, sequences frame scan and
// response emission. Uses mrs_pkg.
module mrs_ctrl
    import mrs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        in_cmd,
    input  mrs_status_t status,
    output mrs_cmd_t    cmd
);
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_cmd == CMD_BYTE)
                    begin
                        cmd.rx_write = 1'b1;
                    end
                    else
                    begin
                        cmd.tick = 1'b1;
                        if (status.frame_end)
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    if (status.reply)
                    begin
                        cmd.emit_start = 1'b1;
                        state_next     = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_step = 1'b1;
                    if (status.emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.rx_write || cmd.tick) |-> (state_reg == ST_IDLE))
        else $error("item taken outside idle");
    a_scan_enter: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_start |=> (state_reg == ST_SCAN))
        else $error("scan start without scan state");
    a_emit_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_step && status.emit_last) |=> (state_reg == ST_IDLE))
        else $error("emission did not end after last byte");
endmodule

/* sv/modbus_rtu_register_slave.sv */
// Top level of the Modbus RTU register slave: APB configuration registers,
// controller and datapath. Uses mrs_pkg, mrs_ctrl, mrs_datapath.
//
// Usage: in_data carries either a received UART byte (cmd 0) or a
// one-millisecond tick (cmd 1). When a tick ends a frame, the buffered
// frame is read from the receive RAM one byte a cycle for the CRC check.
// A valid request then produces a response of 5 to 15 bytes on out_data,
// one per cycle while out_ready is high; last marks the final CRC byte.
// No new item is taken during the scan or while response bytes are still
// being generated; the last byte may wait in the output register while
// the next item is taken. A stalled receiver simply holds the current
// byte. Reset clears the receive count, idle timer, holding registers,
// slave_address (1) and idle_ticks (5).
// Configuration registers: slave_address at 0x0, idle_ticks at 0x4.
module modbus_rtu_register_slave
    import mrs_pkg::*;
#(
    parameter int RX_DEPTH  = 64,
    parameter int FRAME_MAX = 60,
    parameter int NUM_REGS  = 5
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [7:0]  slave_address_reg;
    logic [7:0]  idle_ticks_reg;
    logic        cfg_we;
    mrs_cmd_t    cmd;
    mrs_status_t status;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;
    assign prdata = (paddr[2:1] == ADDR_SLAVE) ? {24'h0, slave_address_reg}
                                                : {24'h0, idle_ticks_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_address_reg <= 8'd1;
            idle_ticks_reg    <= 8'd5;
        end
        else if (cfg_we)
        begin
            if ({1'b0, paddr[2]} == ADDR_SLAVE)
            begin
                slave_address_reg <= pwdata[7:0];
            end
            else
            begin
                idle_ticks_reg <= pwdata[7:0];
            end
        end
    end

    mrs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_cmd   (in_data.cmd),
        .status   (status),
        .cmd      (cmd)
    );

    mrs_datapath #(
        .RX_DEPTH  (RX_DEPTH),
        .FRAME_MAX (FRAME_MAX),
        .NUM_REGS  (NUM_REGS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .rx_byte       (in_data.rx_byte),
        .slave_address (slave_address_reg),
        .idle_ticks    (idle_ticks_reg),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .out_data      (out_data)
    );
endmodule

/* test/testbench.sv */
// Testbench for modbus_rtu_register_slave: drives UART-byte and tick
// transactions, predicts reply bytes from a local slave model and checks them.
// Depends on mrs_pkg and the RTL top level.
module testbench;
    import mrs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NREGS    = 5;
    localparam int RXDEPTH  = 64;
    localparam int FRMMAX   = 60;
    localparam int WDOG_MAX = 200000;
    localparam logic [7:0] FC_ODD = 8'h2B;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    modbus_rtu_register_slave i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // slave model state
    logic [7:0] m_buf [RXDEPTH];
    int         m_count;
    int         m_snap;
    int         m_idle;
    logic [7:0] m_regs [NREGS];
    logic [7:0] m_addr;
    logic [7:0] m_idle_ticks;

    in_item_t   pending_q [$];
    out_item_t  reply_q [$];
    int         n_sent;
    int         n_replies;
    int         n_checked;
    int         errors;
    int         src_idle_pct;
    int         snk_stall_pct;
    int         wdog;
    bit         in_acc;
    bit         out_acc;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = 1'b1;
            #4 clk = 1'b0;
        end
    end

    function automatic logic [15:0] crc_over(input logic [7:0] b [], input int n);
        logic [15:0] c;
        c = 16'hFFFF;
        for (int i = 0; i < n; i++)
        begin
            c = c ^ {8'h00, b[i]};
            for (int k = 0; k < 8; k++)
                c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
        end
        return c;
    endfunction

    task automatic push_reply(input logic [7:0] msg [], input int n);
        logic [15:0] c;
        out_item_t   r;
        c = crc_over(msg, n);
        msg[n]     = c[7:0];
        msg[n + 1] = c[15:8];
        for (int i = 0; i < n + 2; i++)
        begin
            r.tx_byte = msg[i];
            r.last    = (i == n + 1);
            reply_q.push_back(r);
        end
        n_replies++;
    endtask

    task automatic push_exception(input logic [7:0] msg [], input logic [7:0] fc,
                                  input logic [7:0] code);
        msg[1] = fc | FC_EXC_BIT;
        msg[2] = code;
        push_reply(msg, 3);
    endtask

    task automatic close_frame();
        logic [7:0]  f [];
        logic [7:0]  msg [];
        logic [15:0] c;
        int          len;
        int          start;
        int          cnt;
        len = (m_count < FRMMAX) ? m_count : FRMMAX;
        m_count = 0;
        m_snap  = 0;
        m_idle  = 0;
        msg = new[16];
        f = new[len > 0 ? len : 1];
        for (int i = 0; i < len; i++)
            f[i] = m_buf[i];
        if (len < MIN_FRAME || f[0] != m_addr)
            return;
        c = crc_over(f, len - 2);
        if (f[len - 2] != c[7:0] || f[len - 1] != c[15:8])
            return;
        msg[0] = f[0];
        if (f[1] != FC_READ && f[1] != FC_WRITE)
        begin
            push_exception(msg, f[1], EXC_FUNC);
            return;
        end
        if (len < FULL_FRAME)
        begin
            push_exception(msg, f[1], EXC_VALUE);
            return;
        end
        start = {f[2], f[3]};
        if (f[1] == FC_READ)
        begin
            cnt = {f[4], f[5]};
            if (start >= NREGS || cnt > MAX_READ || start + cnt > NREGS)
            begin
                push_exception(msg, f[1], EXC_ADDR);
                return;
            end
            msg[1] = FC_READ;
            msg[2] = 8'(cnt * 2);
            for (int i = 0; i < cnt; i++)
            begin
                msg[3 + 2 * i] = 8'h00;
                msg[4 + 2 * i] = m_regs[start + i];
            end
            push_reply(msg, 3 + 2 * cnt);
            return;
        end
        if (start >= NREGS)
        begin
            push_exception(msg, f[1], EXC_ADDR);
            return;
        end
        m_regs[start] = f[5];
        for (int i = 0; i < 6; i++)
            msg[i] = f[i];
        push_reply(msg, 6);
    endtask

    task automatic model_step(input in_item_t t);
        if (t.cmd == CMD_BYTE)
        begin
            if (m_count < RXDEPTH)
            begin
                m_buf[m_count] = t.rx_byte;
                m_count++;
            end
        end
        else if (m_count == 0)
            m_snap = 0;
        else if (m_snap != m_count)
        begin
            m_snap = m_count;
            m_idle = 0;
        end
        else
        begin
            if (m_idle < 255)
                m_idle++;
            if (m_idle >= m_idle_ticks)
                close_frame();
        end
    endtask

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_acc)
            begin
                if (in_acc)
                    void'(pending_q.pop_front());
                if (pending_q.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data  <= pending_q[0];
                end
                else
                    in_valid <= 1'b0;
            end
            out_ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_acc  = in_valid && in_ready;
            out_acc = out_valid && out_ready;
            if (in_acc)
            begin
                model_step(in_data);
                n_sent++;
            end
            if (out_acc)
            begin
                if (reply_q.size() == 0)
                begin
                    $error("unexpected reply byte %h", out_data.tx_byte);
                    errors++;
                end
                else
                begin
                    if (out_data.tx_byte !== reply_q[0].tx_byte)
                    begin
                        $error("tx_byte expected %h actual %h", reply_q[0].tx_byte,
                               out_data.tx_byte);
                        errors++;
                    end
                    if (out_data.last !== reply_q[0].last)
                    begin
                        $error("last expected %b actual %b", reply_q[0].last,
                               out_data.last);
                        errors++;
                    end
                    void'(reply_q.pop_front());
                    n_checked++;
                end
            end
            if (in_acc || out_acc)
                wdog <= 0;
            else
                wdog <= wdog + 1;
            if (wdog > WDOG_MAX)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic wait_drain();
        while (pending_q.size() != 0 || in_valid || reply_q.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic reg_write(input logic [2:0] a, input logic [7:0] v);
        @(negedge clk);
        psel = 1'b1; pwrite = 1'b1; paddr = a; pwdata = {24'h0, v};
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        if (a == 3'(ADDR_SLAVE) * 4)
            m_addr = v;
        else
            m_idle_ticks = v;
    endtask

    task automatic add_byte(input logic [7:0] b);
        in_item_t t;
        t.cmd = CMD_BYTE;
        t.rx_byte = b;
        pending_q.push_back(t);
    endtask

    task automatic add_ticks(input int n);
        in_item_t t;
        for (int i = 0; i < n; i++)
        begin
            t.cmd = CMD_TICK;
            t.rx_byte = 8'($urandom);
            pending_q.push_back(t);
        end
    endtask

    // queues a frame; bad_crc corrupts the checksum
    task automatic add_frame(input logic [7:0] body [], input int n, input bit bad_crc);
        logic [15:0] c;
        c = crc_over(body, n);
        if (bad_crc)
            c = c ^ 16'h0100;
        for (int i = 0; i < n; i++)
            add_byte(body[i]);
        add_byte(c[7:0]);
        add_byte(c[15:8]);
        add_ticks(int'(m_idle_ticks) + 2);
    endtask

    task automatic add_req(input logic [7:0] ad, input logic [7:0] fc,
                           input logic [15:0] s, input logic [15:0] v);
        logic [7:0] b [];
        b = '{ad, fc, s[15:8], s[7:0], v[15:8], v[7:0]};
        add_frame(b, 6, 1'b0);
    endtask

    task automatic add_random_frame();
        logic [7:0] b [];
        int         k;
        int         n;
        k = $urandom_range(99);
        if (k < 70)
            add_req(($urandom_range(9) == 0) ? 8'($urandom) : m_addr,
                    ($urandom_range(1)) ? FC_READ : FC_WRITE,
                    16'($urandom_range(6))
                        | (($urandom_range(15) == 0) ? 16'h8000 : 16'h0000),
                    ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(5)));
        else
        begin
            n = (k < 85) ? $urandom_range(0, 8) : $urandom_range(6, 12);
            b = new[n + 1];
            b[0] = m_addr;
            for (int i = 1; i <= n; i++)
                b[i] = 8'($urandom);
            if (n >= 1 && $urandom_range(1))
                b[1] = FC_WRITE;
            if ($urandom_range(3) == 0)
                add_byte(8'($urandom));
            else
                add_frame(b, n + 1, $urandom_range(4) == 0);
        end
    endtask

    task automatic run_phase(input int frames, input int si, input int ss);
        src_idle_pct  = si;
        snk_stall_pct = ss;
        for (int i = 0; i < frames; i++)
            add_random_frame();
        wait_drain();
    endtask

    initial
    begin
        logic [7:0] b [];
        rst_n = 1'b0; in_valid = 1'b0; in_data = '0; out_ready = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        src_idle_pct = 0; snk_stall_pct = 0;
        n_sent = 0; n_replies = 0; n_checked = 0; errors = 0; wdog = 0;
        in_acc = 1'b0; out_acc = 1'b0;
        m_count = 0; m_snap = 0; m_idle = 0; m_addr = 8'd1; m_idle_ticks = 8'd5;
        for (int i = 0; i < NREGS; i++)
            m_regs[i] = '0;
        repeat (12) @(posedge clk);
        rst_n = 1'b1;

        // directed: defaults, register read-back, odd function, long write
        add_req(8'd1, FC_WRITE, 16'd4, 16'h00FF);
        wait_drain();
        reg_write(3'(ADDR_IDLE) * 4, 8'd1);
        add_req(8'd1, FC_READ, 16'd0, 16'd5);
        b = '{8'd1, FC_ODD};
        add_frame(b, 2, 1'b0);
        b = '{8'd1, FC_WRITE, 8'd0, 8'd2, 8'd0, 8'h5A, 8'h11, 8'h22};
        add_frame(b, 8, 1'b0);
        wait_drain();

        // receive buffer overflow at the top station address
        reg_write(3'(ADDR_SLAVE) * 4, 8'd247);
        add_byte(8'd247);
        for (int i = 1; i < 65; i++)
            add_byte(8'($urandom));
        add_ticks(3);
        wait_drain();

        reg_write(3'(ADDR_SLAVE) * 4, 8'($urandom_range(1, 247)));
        reg_write(3'(ADDR_IDLE) * 4, 8'($urandom_range(1, 2)));
        run_phase(2, 0, 0);
        run_phase(2, 78, 0);
        run_phase(2, 0, 78);
        reg_write(3'(ADDR_SLAVE) * 4, 8'd1);
        reg_write(3'(ADDR_IDLE) * 4, 8'd2);
        run_phase(2, 10, 10);

        $display("Covered %0d transactions, %0d replies predicted, %0d reply bytes checked.",
                 n_sent, n_replies, n_checked);
        $display("Reads, writes, exceptions, buffer overflow and stalls on both sides.");
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

/* modbus_rtu_register_slave.f */
sv/mrs_pkg.sv
sv/mrs_ram.sv
sv/mrs_datapath.sv
sv/mrs_ctrl.sv
sv/modbus_rtu_register_slave.sv
test/testbench.sv
